@@ rtl/core/mcb_pkg.sv @@
// Package: shared constants, types and arithmetic helpers of the multichannel biquad.
`timescale 1ns / 1ps

package mcb_pkg;

  localparam int unsigned FracBits  = 14;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned StateW    = 32;
  localparam int unsigned AccW      = 34;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgAddrW  = 6;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 24;

  // register indexes (byte address is 8 * index)
  localparam logic [2:0] RegB0     = 3'd0;
  localparam logic [2:0] RegB1     = 3'd1;
  localparam logic [2:0] RegB2     = 3'd2;
  localparam logic [2:0] RegA1     = 3'd3;
  localparam logic [2:0] RegA2     = 3'd4;
  localparam logic [2:0] RegOrders = 3'd5;
  localparam logic [2:0] RegCount  = 3'd6;
  localparam logic [2:0] RegActive = 3'd7;

  // section order codes
  localparam logic [1:0] OrdBypass = 2'd0;
  localparam logic [1:0] OrdFirst  = 2'd1;
  localparam logic [1:0] OrdSecond = 2'd2;

  // input kinds
  localparam logic ActFilter = 1'b0;
  localparam logic ActClear  = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [StateW-1:0]  state_word_t;
  typedef logic signed [AccW-1:0]    acc_t;

  function automatic logic signed [CoefW-1:0] coef_sel(input logic [63:0] packed_c,
                                                       input logic [1:0]  sec);
    return packed_c[16*sec +: 16];
  endfunction

  function automatic sample_t sat16(input logic signed [AccW-FracBits-1:0] v);
    sample_t r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[SampleW-1:0];
    return r;
  endfunction

  function automatic state_word_t sat32(input acc_t v);
    state_word_t r;
    if (v > 34'sh0_7fff_ffff) r = 32'sh7fff_ffff;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[StateW-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/multichannel_cascaded_biquad_top.sv @@
// Top level: multichannel cascaded biquad filter with shared multiplier and state RAM.
`timescale 1ns / 1ps

// Multichannel cascaded biquad, transposed direct form II, Q2.14 coefficients.
// Input stream (s_axis): one word is either a sample to filter on a channel
// (tuser = 0) or a clear of all filter state (tuser = 1). Output stream
// (m_axis): one word per filtered sample; a clear gives no word.
// Per-channel state (two 32-bit words per section) lives in one RAM row per
// channel/section, 64 bits wide, read through a registered port. A row valid bit
// per entry makes never-written or cleared rows read as zero, so a clear only
// resets the valid bits and reset needs no sweep of the RAM.
// Sequencing: one shared 16x16 multiplier serves every section in turn.
// A second-order section steps through StSec, StY, StA1, StB2, StA2 and StWr,
// a first-order section skips StA2, and a bypass section takes only StSec.
// After the last section StSec moves to StOut, which loads the output register
// and returns to idle, where the input is ready again.
// A channel at or above active_channels, or at or above CHANNELS, passes straight
// through with status 1, going from idle directly to StOut.
// The input takes one word at a time; a finished word waits in the output
// register, and the next word may be accepted meanwhile. If the receiver
// stalls, the block holds its next result until the output register frees.
// Reset restores the configuration and marks all state rows as zero.
// Configuration goes through the APB port at byte address 8*index and must be
// written only while the block is idle; the block itself does not enforce it.
module multichannel_cascaded_biquad_top #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned SECTIONS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] channel, [18:3] sample_in, [23:19] zero
  input  logic [mcb_pkg::InTdataW-1:0]   s_axis_tdata,
  // [0] action
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] sample_out, [18:16] channel_out, [23:19] zero
  output logic [mcb_pkg::OutTdataW-1:0]  m_axis_tdata,
  // [0] status
  output logic                           m_axis_tuser,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mcb_pkg::CfgAddrW-1:0]   paddr,
  input  logic [mcb_pkg::CfgDataW-1:0]   pwdata,
  output logic [mcb_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);
  import mcb_pkg::*;

  localparam int unsigned Rows = CHANNELS * SECTIONS;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSec  = 3'd1;  // pick section, issue read, b0*x
  localparam logic [2:0] StY    = 3'd2;  // output y, b1*x
  localparam logic [2:0] StA1   = 3'd3;  // a1*y
  localparam logic [2:0] StB2   = 3'd4;  // new s0, b2*x
  localparam logic [2:0] StA2   = 3'd5;  // a2*y
  localparam logic [2:0] StWr   = 3'd6;  // new s1, write row
  localparam logic [2:0] StOut  = 3'd7;  // hand result to output register

  // ---------------- configuration registers ----------------
  logic [63:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [7:0]  orders_q;
  logic [2:0]  count_q;
  logic [3:0]  active_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q     <= '0;
      b1_q     <= '0;
      b2_q     <= '0;
      a1_q     <= '0;
      a2_q     <= '0;
      orders_q <= '0;
      count_q  <= '0;
      active_q <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegB0:     b0_q     <= pwdata;
        RegB1:     b1_q     <= pwdata;
        RegB2:     b2_q     <= pwdata;
        RegA1:     a1_q     <= pwdata;
        RegA2:     a2_q     <= pwdata;
        RegOrders: orders_q <= pwdata[7:0];
        RegCount:  count_q  <= pwdata[2:0];
        RegActive: active_q <= pwdata[3:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegB0:     prdata = b0_q;
      RegB1:     prdata = b1_q;
      RegB2:     prdata = b2_q;
      RegA1:     prdata = a1_q;
      RegA2:     prdata = a2_q;
      RegOrders: prdata = {56'd0, orders_q};
      RegCount:  prdata = {61'd0, count_q};
      RegActive: prdata = {60'd0, active_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------- datapath and sequencer ----------------
  logic [2:0]        state_q, state_d;
  logic [2:0]        sec_q;
  logic [ChanW-1:0]  ch_q;
  sample_t           x_q, y_q;
  logic [1:0]        ord_q;
  logic              status_q;
  state_word_t       s1_q, ns0_q;
  acc_t              acc_q;
  logic signed [31:0] prod_q;
  logic [RowW-1:0]   row_q;

  logic [Rows-1:0]   valid_q;
  logic [63:0]       mem [Rows];
  logic [63:0]       rdata_q;
  logic              rvalid_q;

  logic              in_acc;
  logic [ChanW-1:0]  in_ch;
  sample_t           in_sample;
  logic              reject;
  logic [2:0]        count_eff;
  logic [1:0]        ord_cur;
  logic [RowW-1:0]   row_d;
  logic              rd_en, wr_en;
  state_word_t       rd_s0, rd_s1, ns1;
  acc_t              acc_y;
  logic signed [19:0] acc_y_sh;
  logic signed [CoefW-1:0] mul_a;
  sample_t           mul_b;
  logic signed [31:0] prod_d;
  logic              out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_ch         = s_axis_tdata[2:0];
  assign in_sample     = s_axis_tdata[18:3];
  assign reject        = ({1'b0, in_ch} >= active_q) || (int'(in_ch) >= int'(CHANNELS));
  assign count_eff     = (int'(count_q) > int'(SECTIONS)) ? 3'(SECTIONS) : count_q;
  assign ord_cur       = orders_q[2*sec_q[1:0] +: 2];
  assign row_d         = RowW'(int'(ch_q) * int'(SECTIONS) + int'(sec_q[1:0]));

  // state words of the row just read; an unwritten row reads as zero
  assign rd_s0    = rvalid_q ? rdata_q[31:0]  : '0;
  assign rd_s1    = rvalid_q ? rdata_q[63:32] : '0;
  assign acc_y    = AccW'(prod_q) + AccW'(rd_s0) + acc_t'(34'sd8192);
  assign acc_y_sh = acc_y[AccW-1:FracBits];
  assign ns1      = (ord_q == OrdSecond) ? sat32(acc_q - AccW'(prod_q)) : s1_q;

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    out_load = 1'b0;
    mul_a   = coef_sel(b0_q, sec_q[1:0]);
    mul_b   = x_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && s_axis_tuser == ActFilter) begin
          state_d = reject ? StOut : StSec;
        end
      end
      StSec: begin
        if (sec_q >= count_eff) begin
          state_d = StOut;
        end else if (ord_cur == OrdFirst || ord_cur == OrdSecond) begin
          rd_en   = 1'b1;
          state_d = StY;
        end
      end
      StY: begin
        mul_a   = coef_sel(b1_q, sec_q[1:0]);
        state_d = StA1;
      end
      StA1: begin
        mul_a   = coef_sel(a1_q, sec_q[1:0]);
        mul_b   = y_q;
        state_d = StB2;
      end
      StB2: begin
        mul_a   = coef_sel(b2_q, sec_q[1:0]);
        state_d = (ord_q == OrdSecond) ? StA2 : StWr;
      end
      StA2: begin
        mul_a   = coef_sel(a2_q, sec_q[1:0]);
        mul_b   = y_q;
        state_d = StWr;
      end
      StWr: begin
        wr_en   = 1'b1;
        state_d = StSec;
      end
      StOut: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      sec_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && s_axis_tuser == ActClear) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[row_q] <= 1'b1;
      end
      if (in_acc) begin
        sec_q <= '0;
      end else if ((state_q == StSec && state_d == StSec) || wr_en) begin
        sec_q <= sec_q + 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      ch_q     <= in_ch;
      x_q      <= in_sample;
      status_q <= reject ? StatusRange : StatusOk;
    end
    if (rd_en) begin
      row_q <= row_d;
      ord_q <= ord_cur;
    end
    unique case (state_q)
      StY: begin
        y_q  <= sat16(acc_y_sh);
        s1_q <= rd_s1;
      end
      StA1:    acc_q <= AccW'(prod_q) + ((ord_q == OrdSecond) ? AccW'(s1_q) : '0);
      StB2:    ns0_q <= sat32(acc_q - AccW'(prod_q));
      StA2:    acc_q <= AccW'(prod_q);
      StWr:    x_q   <= y_q;
      default: ;
    endcase
  end

  // state RAM: one row per channel/section, {s1, s0}
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[row_q] <= {ns1, ns0_q};
    end
    if (rd_en) begin
      rdata_q  <= mem[row_d];
      rvalid_q <= valid_q[row_d];
    end
  end

  // ---------------- output register ----------------
  logic        m_valid_q;
  sample_t     out_sample_q;
  logic [2:0]  out_ch_q;
  logic        out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= x_q;
      out_ch_q     <= ch_q;
      out_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, out_ch_q, out_sample_q};
  assign m_axis_tuser  = out_status_q;

  // ---------------- assertions ----------------
  a_clear_wipes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == ActClear) |=> (valid_q == '0))
    else $error("clear did not invalidate all state rows");

  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) ##1 m_axis_tvalid |-> $past(state_q) == StOut)
    else $error("result appeared without passing the output state");

  a_sec_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StY) |-> (int'(sec_q) < int'(SECTIONS)))
    else $error("section index out of range while filtering");

  a_write_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (row_q == $past(row_q)))
    else $error("state row changed between read and write back");

endmodule
